### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Beat payload structs, command classes and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd2;

    // mode field codes
    typedef enum logic [1:0] {
        MODE_PUT   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2
    } t_mode;

    // command class handed from front to back
    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_READ,
        CMD_CLEAR,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  character;
        logic [10:0] cell_index;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] read_entry;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic        scrolled;
    } t_out_beat;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  character;
        logic [10:0] cell_index;
        logic        in_range;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire logic [WIDTH-1:0]           i_wdata,
    input  wire logic                       i_re,
    input  wire logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic      [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: input stage
// Takes input beats, classifies them into commands and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_enable,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_data,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    localparam int CELLS = COLUMNS * ROWS;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd            = '0;
        n_cmd.character  = i_in_data.character;
        n_cmd.cell_index = i_in_data.cell_index;
        n_cmd.in_range   = (32'(i_in_data.cell_index) < 32'(CELLS));
        unique case (t_mode'(i_in_data.mode))
            MODE_PUT:   n_cmd.kind = (i_in_data.character == NEWLINE_CODE) ? CMD_NEWLINE
                                                                           : CMD_PUT;
            MODE_READ:  n_cmd.kind = CMD_READ;
            MODE_CLEAR: n_cmd.kind = CMD_CLEAR;
            default:    n_cmd.kind = CMD_NOP;
        endcase
    end

    assign o_in_ready  = (!r_valid || i_cmd_ready) && i_enable;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_valid <= 1'b1;
                r_cmd   <= n_cmd;
            end else if (i_cmd_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo: two-entry command queue
// Decouples the classifying front from the executing back.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_fifo
    import tcw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  wire t_cmd i_push_data,
    output logic      o_pop_valid,
    input  wire logic i_pop,
    output t_cmd      o_pop_data
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/core/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: command executor
// Owns the cell store, the cursor and the result register; runs the
// fill, scroll and read sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_color,
    output logic            o_init_busy,
    input  wire logic       i_cmd_valid,
    output logic            o_cmd_pop,
    input  wire t_cmd       i_cmd,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_beat       o_out_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
    localparam logic [AW-1:0] LIMIT    = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] LAST     = AW'(CELLS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_COPY,
        S_ZERO,
        S_FILL
    } t_state;

    t_state      r_state;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [AW-1:0] r_base;
    logic [AW-1:0] r_idx;
    logic [AW-1:0] r_wr_addr;
    logic          r_pend;
    logic [15:0]   r_fill_data;
    logic          r_out_valid;
    t_out_beat     r_out;

    logic [RW-1:0] n_row;
    logic [CW-1:0] n_col;
    logic [AW-1:0] n_base;
    logic          wrap;
    logic          scroll_start;
    logic          out_load;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [15:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [15:0]   mem_rdata;

    assign o_cmd_pop   = i_cmd_valid && (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_init_busy = (r_state == S_INIT);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // cursor step for put and newline
    always_comb begin
        wrap         = (i_cmd.kind == CMD_NEWLINE) || (r_col == COL_LAST);
        scroll_start = wrap && (r_row == ROW_LAST);
        n_row        = r_row;
        n_col        = r_col + CW'(1);
        n_base       = r_base;
        if (wrap) begin
            n_col = '0;
            if (!scroll_start) begin
                n_row  = r_row + RW'(1);
                n_base = r_base + COLS_A;
            end
        end
    end

    // result register loads a beat this cycle
    always_comb begin
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd_pop) begin
                    unique case (i_cmd.kind)
                        CMD_PUT, CMD_NEWLINE: out_load = !scroll_start;
                        CMD_READ:             out_load = !i_cmd.in_range;
                        CMD_CLEAR:            out_load = 1'b0;
                        default:              out_load = 1'b1;
                    endcase
                end
            end
            S_READ:         out_load = 1'b1;
            S_ZERO, S_FILL: out_load = (r_idx == LAST);
            default:        out_load = 1'b0;
        endcase
    end

    // store port control
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = r_fill_data;
        mem_re    = 1'b0;
        mem_raddr = r_idx + COLS_A;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd_pop && i_cmd.kind == CMD_PUT) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_base + AW'(r_col);
                    mem_wdata = {i_color, i_cmd.character};
                end
                if (o_cmd_pop && i_cmd.kind == CMD_READ && i_cmd.in_range) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(i_cmd.cell_index);
                end
            end
            S_COPY: begin
                mem_we    = r_pend;
                mem_waddr = r_wr_addr;
                mem_wdata = mem_rdata;
                mem_re    = (r_idx != LIMIT);
            end
            S_ZERO: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_INIT, S_FILL: begin
                mem_we = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_fill_data <= {RESET_COLOR, SPACE_CODE};
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        unique case (i_cmd.kind)
                            CMD_PUT, CMD_NEWLINE: begin
                                r_row  <= n_row;
                                r_col  <= n_col;
                                r_base <= n_base;
                                if (scroll_start) begin
                                    r_idx   <= '0;
                                    r_pend  <= 1'b0;
                                    r_state <= S_COPY;
                                end else begin
                                    r_out <= {16'd0, 5'(n_row), 7'(n_col), 1'b0};
                                end
                            end
                            CMD_READ: begin
                                if (i_cmd.in_range) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_out <= {16'd0, 5'(r_row), 7'(r_col), 1'b0};
                                end
                            end
                            CMD_CLEAR: begin
                                r_fill_data <= {i_color, SPACE_CODE};
                                r_idx       <= '0;
                                r_state     <= S_FILL;
                            end
                            default: begin
                                r_out <= {16'd0, 5'(r_row), 7'(r_col), 1'b0};
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_out   <= {mem_rdata, 5'(r_row), 7'(r_col), 1'b0};
                    r_state <= S_IDLE;
                end
                S_COPY: begin
                    // read one line ahead, write the previous beat's data
                    if (r_idx != LIMIT) begin
                        r_wr_addr <= r_idx;
                        r_idx     <= r_idx + AW'(1);
                        r_pend    <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_state <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == LAST) begin
                        r_out   <= {16'd0, 5'(r_row), 7'(r_col), 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                S_FILL: begin
                    r_idx <= r_idx + AW'(1);
                    if (r_idx == LAST) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_base  <= '0;
                        r_out   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < 32'(ROWS)) && (32'(r_col) < 32'(COLUMNS)))
        else $error("cursor out of range");

    a_base_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base == AW'(32'(r_row) * 32'(COLUMNS)))
        else $error("line base does not match cursor row");

    a_read_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> $past(o_cmd_pop))
        else $error("read sequence entered without a command");

    a_pop_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> !$past(r_out_valid && !i_out_ready))
        else $error("command taken while result slot held");

endmodule

`default_nettype wire

### rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console writer, top level
// Character store with cursor, scroll, clear and cell read-back.
// ----------------------------------------------------------------------------
// Keeps a ROWS x COLUMNS store of 16-bit cells (colour in the high byte,
// character in the low byte) and a cursor. Each input beat yields exactly one
// result beat. After reset the block blanks the whole store (space, colour 2),
// holding o_in_ready low meanwhile. Puts and newlines without scroll stream at
// one per cycle once the queue is primed and while each result is collected;
// a read passes through the read state for the registered store port; a clear
// runs the fill state over every cell; a scrolling put or newline runs the copy
// and zero states, moving or zeroing every cell through the single store write
// port. The front stage and a two-entry queue take beats while the executor is
// busy. The result register holds each result until collected; the executor
// takes the next item no earlier than the cycle in which the waiting result is
// collected. text_color is written through i_cfg_we/i_cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_beat   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_beat       o_out_data,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    // attribute byte for written and cleared cells
    logic [7:0] r_text_color;

    // front -> queue
    logic front_valid;
    logic front_ready;
    t_cmd front_cmd;

    // queue -> back
    logic q_valid;
    logic q_pop;
    t_cmd q_cmd;

    logic init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_wdata;
        end
    end

    // classify beats; blocked during the post-reset blanking pass
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (!init_busy),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (front_ready),
        .o_cmd       (front_cmd)
    );

    tcw_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_cmd),
        .o_pop_valid  (q_valid),
        .i_pop        (q_pop),
        .o_pop_data   (q_cmd)
    );

    // executor: store, cursor, scroll/clear sequencing, result register
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_color     (r_text_color),
        .o_init_busy (init_busy),
        .i_cmd_valid (q_valid),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text console writer
// Drives put, newline, read, clear and unused-mode beats through the valid /
// ready input, with text colour changes between phases. Every result beat is
// compared field by field against an in-bench copy of the console.
// ----------------------------------------------------------------------------

module tb_top;
    import tcw_pkg::*;

    // console geometry, as built
    localparam int COLS  = COLUMNS_DEF;
    localparam int ROWS  = ROWS_DEF;
    localparam int CELLS = COLS * ROWS;

    // mode code the block leaves unused
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int RANDOM_BEATS = 1500;   // random part, ignored beats not counted
    localparam int SETTLE_CYCLES = 8;     // quiet cycles before a colour write
    localparam int HOLD_AT       = 600;   // results seen before the long hold-off
    localparam int HOLD_CYCLES   = 400;   // length of the receiver hold-off
    localparam int END_CYCLES    = 64;    // settle after the last result
    localparam int STUCK_LIMIT   = 20000; // cycles with no beat moving on either side

    typedef enum logic {
        JOB_BEAT,
        JOB_COLOUR
    } t_job_kind;

    // one entry of the sender's work list: a beat, or a colour change that
    // waits for the block to drain first
    typedef struct {
        t_job_kind  kind;
        t_in_beat   beat;
        logic [7:0] colour;
    } t_job;

    // ------------------------------------------------------------------------
    // DUT hook-up
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_in_beat   i_in_data   = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [7:0] i_cfg_wdata = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_beat  o_out_data;

    text_console_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // synchronous reset, held low from the start, then released for good
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Console copy: screen, cursor and colour as the block should hold them
    // ------------------------------------------------------------------------
    logic [15:0] screen_copy [0:CELLS-1];
    int          cursor_row_copy = 0;
    int          cursor_col_copy = 0;
    logic [7:0]  colour_copy     = RESET_COLOR;

    // run statistics
    int n_puts = 0, n_newlines = 0, n_reads = 0, n_far_reads = 0;
    int n_clears = 0, n_spare = 0, n_scrolls = 0, n_colour_writes = 0;

    initial begin
        for (int i = 0; i < CELLS; i++)
            screen_copy[i] = {RESET_COLOR, SPACE_CODE};
    end

    // applies one beat to the console copy and returns the result it must give
    function automatic t_out_beat console_step(t_in_beat b);
        t_out_beat r;
        int        pos;
        r = '0;
        case (b.mode)
            MODE_PUT: begin
                n_puts++;
                if (b.character == NEWLINE_CODE) begin
                    // newline writes nothing, just moves the cursor
                    n_newlines++;
                    cursor_col_copy = 0;
                    cursor_row_copy++;
                end else begin
                    pos = cursor_row_copy * COLS + cursor_col_copy;
                    if (pos < CELLS)
                        screen_copy[pos] = {colour_copy, b.character};
                    cursor_col_copy++;
                    if (cursor_col_copy >= COLS) begin
                        cursor_col_copy = 0;
                        cursor_row_copy++;
                    end
                end
                if (cursor_row_copy >= ROWS) begin
                    // lines move up one; the freed bottom line is zero, not blank
                    for (int i = 0; i < CELLS - COLS; i++)
                        screen_copy[i] = screen_copy[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++)
                        screen_copy[i] = '0;
                    cursor_row_copy = ROWS - 1;
                    r.scrolled = 1'b1;
                    n_scrolls++;
                end
            end
            MODE_READ: begin
                n_reads++;
                if (b.cell_index < CELLS)
                    r.read_entry = screen_copy[b.cell_index];
                else
                    n_far_reads++;  // past the store reads as zero
            end
            MODE_CLEAR: begin
                n_clears++;
                for (int i = 0; i < CELLS; i++)
                    screen_copy[i] = {colour_copy, SPACE_CODE};
                cursor_row_copy = 0;
                cursor_col_copy = 0;
            end
            default: n_spare++;  // unused mode: no change at all
        endcase
        r.cursor_row    = 5'(cursor_row_copy);
        r.cursor_column = 7'(cursor_col_copy);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: work list filled by the stimulus block, drained by the driver
    // ------------------------------------------------------------------------
    t_job      job_q[$];
    int        beats_sent   = 0;
    int        results_seen = 0;
    int        gap_left     = 0;
    int        quiet_cycles = 0;
    logic      beat_taken   = 1'b0;  // a beat went in at the last edge
    t_out_beat beat_outcome = '0;    // and this is what it must produce

    // per-beat idle before the next offer; one band in four runs flat out
    function automatic int sender_gap(int n);
        if ((n / 200) % 4 == 1)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    always @(posedge i_clk) begin
        logic       nxt_valid;
        t_in_beat   nxt_data;
        logic       nxt_we;
        logic [7:0] nxt_wdata;
        logic       took;
        t_out_beat  outcome;
        t_job       head;

        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        nxt_we    = 1'b0;
        nxt_wdata = i_cfg_wdata;
        took      = 1'b0;
        outcome   = '0;

        if (!i_rst_n) begin
            nxt_valid    = 1'b0;
            gap_left     = 0;
            quiet_cycles = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                took      = 1'b1;
                outcome   = console_step(i_in_data);
                nxt_valid = 1'b0;
                gap_left  = sender_gap(beats_sent);
            end

            // block counts as idle once every beat sent has its result back
            if (!i_in_valid && beats_sent == results_seen)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            if (!nxt_valid && job_q.size() != 0) begin
                head = job_q[0];
                if (gap_left > 0) begin
                    gap_left--;
                end else if (head.kind == JOB_BEAT) begin
                    nxt_valid = 1'b1;
                    nxt_data  = head.beat;
                    void'(job_q.pop_front());
                end else if (quiet_cycles >= SETTLE_CYCLES) begin
                    // colour change only with the block drained; the copy
                    // follows now, the next beat cannot land before the write
                    nxt_we       = 1'b1;
                    nxt_wdata    = head.colour;
                    colour_copy  = head.colour;
                    n_colour_writes++;
                    quiet_cycles = 0;
                    void'(job_q.pop_front());
                end
            end
        end

        i_in_valid   <= nxt_valid;
        i_in_data    <= nxt_data;
        i_cfg_we     <= nxt_we;
        i_cfg_wdata  <= nxt_wdata;
        beat_taken   <= took;
        beat_outcome <= outcome;
        if (took)
            beats_sent <= beats_sent + 1;
    end

    // ------------------------------------------------------------------------
    // Receiver: collects result beats and checks them in order
    // ------------------------------------------------------------------------
    t_out_beat awaited_results[$];
    int        stall_left = 0;
    int        hold_left  = 0;
    logic      hold_done  = 1'b0;
    int        mismatches = 0;

    function automatic int receiver_stall(int n);
        if ((n / 250) % 4 == 2)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        logic      nxt_ready;
        logic      took;

        took = 1'b0;
        if (!i_rst_n) begin
            nxt_ready  = 1'b0;
            stall_left = 0;
        end else begin
            // a beat accepted at the last edge cannot have its result before now
            if (beat_taken)
                awaited_results.push_back(beat_outcome);

            if (o_out_valid && i_out_ready) begin
                took = 1'b1;
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing awaited: %p", o_out_data);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("read_entry", want.read_entry, o_out_data.read_entry);
                    check_field("cursor_row", 16'(want.cursor_row),
                                16'(o_out_data.cursor_row));
                    check_field("cursor_column", 16'(want.cursor_column),
                                16'(o_out_data.cursor_column));
                    check_field("scrolled", 16'(want.scrolled), 16'(o_out_data.scrolled));
                end
                stall_left = receiver_stall(results_seen);
            end

            // one long hold-off: the sender keeps offering, the block backs up
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                nxt_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
        end

        i_out_ready <= nxt_ready;
        if (took)
            results_seen <= results_seen + 1;
    end

    // ------------------------------------------------------------------------
    // Watchdog: long enough for the clearing pass after reset, a full scroll
    // and the hold-off stacked together, several times over
    // ------------------------------------------------------------------------
    int stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $error("no beat moved for %0d cycles, %0d results outstanding",
                   stuck_cycles, beats_sent - results_seen);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic void add_beat(logic [1:0] m, logic [7:0] ch, logic [10:0] idx);
        t_job j;
        j.kind            = JOB_BEAT;
        j.beat.mode       = m;
        j.beat.character  = ch;
        j.beat.cell_index = idx;
        j.colour          = '0;
        job_q.push_back(j);
    endfunction

    function automatic void add_colour(logic [7:0] c);
        t_job j;
        j.kind   = JOB_COLOUR;
        j.beat   = '0;
        j.colour = c;
        job_q.push_back(j);
    endfunction

    // biased towards the bottom rows, where text sits once scrolling starts
    function automatic logic [10:0] pick_cell();
        int p;
        p = $urandom_range(0, 9);
        if (p < 4)
            return 11'($urandom_range(CELLS - 5 * COLS, CELLS - 1));
        if (p < 8)
            return 11'($urandom_range(0, CELLS - 1));
        return 11'($urandom_range(0, 2047));
    endfunction

    initial begin
        int         counted;
        int         pick;
        int         len;
        logic [7:0] ch;
        logic [7:0] c;

        // directed part; a read goes first so nothing else starts before the
        // block has finished blanking its store after reset
        add_beat(MODE_READ, 8'h00, 11'd0);
        add_beat(MODE_READ, 8'hFF, 11'(CELLS - 1));
        add_beat(MODE_READ, 8'h00, 11'(CELLS));           // just past the store
        add_beat(MODE_READ, 8'h00, 11'h7FF);              // top of the index field
        add_beat(MODE_SPARE, 8'hFF, 11'h7FF);             // unused mode
        add_beat(MODE_PUT, 8'h00, 11'd0);
        add_beat(MODE_PUT, 8'hFF, 11'h7FF);
        add_beat(MODE_PUT, NEWLINE_CODE, 11'd0);
        add_colour(8'hFF);
        add_beat(MODE_PUT, 8'h41, 11'd0);
        add_beat(MODE_READ, 8'h00, 11'd0);
        add_beat(MODE_READ, 8'h00, 11'd1);
        add_beat(MODE_READ, 8'h00, 11'(COLS));
        add_beat(MODE_READ, 8'h00, 11'(COLS + 1));
        add_colour(8'h00);
        add_beat(MODE_PUT, 8'h7E, 11'd0);
        add_beat(MODE_CLEAR, 8'h00, 11'd0);               // blanks in colour 0
        add_beat(MODE_READ, 8'h00, 11'd0);
        add_beat(MODE_READ, 8'h00, 11'(CELLS - 1));
        add_colour(RESET_COLOR);

        // random part, built from bursts: mostly runs of text and reads,
        // newline runs to drive scrolling, a few clears, colour changes and
        // some noise with all fields random
        counted = 0;
        while (counted < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                len = $urandom_range(1, 100);
                for (int k = 0; k < len; k++) begin
                    ch = ($urandom_range(0, 19) == 0) ? NEWLINE_CODE
                                                      : 8'($urandom_range(0, 255));
                    add_beat(MODE_PUT, ch, 11'($urandom_range(0, 2047)));
                end
                counted += len;
            end else if (pick < 58) begin
                len = $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    add_beat(MODE_PUT, NEWLINE_CODE, 11'($urandom_range(0, 2047)));
                counted += len;
            end else if (pick < 85) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    add_beat(MODE_READ, 8'($urandom_range(0, 255)), pick_cell());
                counted += len;
            end else if (pick < 88) begin
                add_beat(MODE_CLEAR, 8'($urandom_range(0, 255)),
                         11'($urandom_range(0, 2047)));
                counted++;
            end else if (pick < 94) begin
                case ($urandom_range(0, 3))
                    0:       c = 8'h00;
                    1:       c = 8'hFF;
                    default: c = 8'($urandom_range(0, 255));
                endcase
                add_colour(c);
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) begin
                    pick = $urandom_range(0, 3);
                    add_beat(2'(pick), 8'($urandom_range(0, 255)),
                             11'($urandom_range(0, 2047)));
                    if (2'(pick) != MODE_SPARE)
                        counted++;
                end
            end
        end

        // wait for the list to empty and every result to come back
        while (job_q.size() != 0 || i_in_valid || beats_sent != results_seen)
            @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);

        if (awaited_results.size() != 0) begin
            $error("%0d results never arrived", awaited_results.size());
            mismatches++;
        end

        $display("Run: %0d results checked; %0d puts (%0d newlines), %0d reads (%0d past end)",
                 results_seen, n_puts, n_newlines, n_reads, n_far_reads);
        $display("     %0d clears, %0d unused-mode beats, %0d scrolls, %0d colour writes",
                 n_clears, n_spare, n_scrolls, n_colour_writes);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
